@@ hdl/cst_pkg.sv @@
package cst_pkg;

  localparam int OffsetBitsDef   = 20;
  localparam int CounterBitsDef  = 16;
  localparam int KeywordCharsDef = 8;
  localparam int TypeBits        = 6;
  localparam int MaxTokens       = 3;

  typedef enum logic [3:0] {
    M_IDLE, M_HOLD, M_IDENT, M_ZERO, M_NUMBER, M_ADDR,
    M_STR, M_STR_ESC, M_LINE, M_BLOCK, M_BLOCK_STAR
  } mode_e;

  typedef enum logic [TypeBits-1:0] {
    TK_EOF, TK_EQ_EQ, TK_EQ, TK_NE, TK_NOT, TK_LE, TK_LT, TK_GE, TK_GT,
    TK_AND_AND, TK_OR_OR, TK_INC, TK_PLUS, TK_DEC, TK_MINUS, TK_STAR,
    TK_DIV, TK_MOD, TK_SEMI, TK_COMMA, TK_DOT, TK_COLON, TK_QUEST,
    TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_LBRACK, TK_RBRACK,
    TK_UNKNOWN, TK_IDENT, TK_NUMBER, TK_STRING, TK_ADDR,
    KW_CONTRACT, KW_FUNCTION, KW_RETURN, KW_IF, KW_ELSE, KW_WHILE, KW_FOR,
    KW_VAR, KW_CONST, KW_PUBLIC, KW_PRIVATE, KW_VIEW, KW_PURE, KW_PAYABLE,
    KW_UINT8, KW_UINT16, KW_UINT32, KW_UINT64, KW_UINT256, KW_INT8,
    KW_INT16, KW_INT32, KW_INT64, KW_INT256, KW_BOOL, KW_ADDRESS,
    KW_BYTES, KW_STRING, TK_BOOL_LIT
  } tok_e;

  typedef struct packed {
    logic       has_pair;
    logic [7:0] pair;
    tok_e       two;
    tok_e       one;
  } held_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_op_start(input logic [7:0] c);
    return c == "=" || c == "!" || c == "<" || c == ">" || c == "&" ||
           c == "|" || c == "+" || c == "-" || c == "/";
  endfunction

  function automatic tok_e single_type(input logic [7:0] c);
    tok_e t;
    t = TK_UNKNOWN;
    if (c == "*") t = TK_STAR;
    if (c == "%") t = TK_MOD;
    if (c == ";") t = TK_SEMI;
    if (c == ",") t = TK_COMMA;
    if (c == ".") t = TK_DOT;
    if (c == ":") t = TK_COLON;
    if (c == "?") t = TK_QUEST;
    if (c == "(") t = TK_LPAREN;
    if (c == ")") t = TK_RPAREN;
    if (c == "{") t = TK_LBRACE;
    if (c == "}") t = TK_RBRACE;
    if (c == "[") t = TK_LBRACK;
    if (c == "]") t = TK_RBRACK;
    return t;
  endfunction

  function automatic held_t held_kinds(input logic [7:0] h);
    held_t k;
    k = '{has_pair: 1'b0, pair: 8'h00, two: TK_UNKNOWN, one: TK_UNKNOWN};
    if (h == "=") k = '{1'b1, 8'("="), TK_EQ_EQ, TK_EQ};
    if (h == "!") k = '{1'b1, 8'("="), TK_NE, TK_NOT};
    if (h == "<") k = '{1'b1, 8'("="), TK_LE, TK_LT};
    if (h == ">") k = '{1'b1, 8'("="), TK_GE, TK_GT};
    if (h == "&") k = '{1'b1, 8'("&"), TK_AND_AND, TK_UNKNOWN};
    if (h == "|") k = '{1'b1, 8'("|"), TK_OR_OR, TK_UNKNOWN};
    if (h == "+") k = '{1'b1, 8'("+"), TK_INC, TK_PLUS};
    if (h == "-") k = '{1'b1, 8'("-"), TK_DEC, TK_MINUS};
    if (h == "/") k = '{1'b0, 8'h00, TK_DIV, TK_DIV};
    return k;
  endfunction

  // w holds the first eight chars, first char in the top byte
  function automatic tok_e kw_lookup(input logic [63:0] w, input logic [3:0] len);
    tok_e t;
    t = TK_IDENT;
    unique case (len)
      4'd2: if (w[63:48] == "if") t = KW_IF;
      4'd3: begin
        if (w[63:40] == "for") t = KW_FOR;
        if (w[63:40] == "var") t = KW_VAR;
      end
      4'd4: begin
        if (w[63:32] == "else") t = KW_ELSE;
        if (w[63:32] == "view") t = KW_VIEW;
        if (w[63:32] == "pure") t = KW_PURE;
        if (w[63:32] == "int8") t = KW_INT8;
        if (w[63:32] == "bool") t = KW_BOOL;
        if (w[63:32] == "true") t = TK_BOOL_LIT;
      end
      4'd5: begin
        if (w[63:24] == "while") t = KW_WHILE;
        if (w[63:24] == "const") t = KW_CONST;
        if (w[63:24] == "uint8") t = KW_UINT8;
        if (w[63:24] == "int16") t = KW_INT16;
        if (w[63:24] == "int32") t = KW_INT32;
        if (w[63:24] == "int64") t = KW_INT64;
        if (w[63:24] == "bytes") t = KW_BYTES;
        if (w[63:24] == "false") t = TK_BOOL_LIT;
      end
      4'd6: begin
        if (w[63:16] == "return") t = KW_RETURN;
        if (w[63:16] == "public") t = KW_PUBLIC;
        if (w[63:16] == "uint16") t = KW_UINT16;
        if (w[63:16] == "uint32") t = KW_UINT32;
        if (w[63:16] == "uint64") t = KW_UINT64;
        if (w[63:16] == "int256") t = KW_INT256;
        if (w[63:16] == "string") t = KW_STRING;
      end
      4'd7: begin
        if (w[63:8] == "private") t = KW_PRIVATE;
        if (w[63:8] == "payable") t = KW_PAYABLE;
        if (w[63:8] == "uint256") t = KW_UINT256;
        if (w[63:8] == "address") t = KW_ADDRESS;
      end
      4'd8: begin
        if (w == "contract") t = KW_CONTRACT;
        if (w == "function") t = KW_FUNCTION;
      end
      default: t = TK_IDENT;
    endcase
    return t;
  endfunction

endpackage

@@ hdl/cst_front.sv @@
module cst_front #(
  parameter int OffsetBits   = cst_pkg::OffsetBitsDef,
  parameter int CounterBits  = cst_pkg::CounterBitsDef,
  parameter int KeywordChars = cst_pkg::KeywordCharsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [7:0]                              char_code_i,
  input  logic                                    end_of_source_i,
  input  logic                                    q_ready_i,
  output logic                                    push_o,
  output logic [1:0]                              cnt_o,
  output logic [cst_pkg::MaxTokens-1:0][cst_pkg::TypeBits-1:0] tt_o,
  output logic [cst_pkg::MaxTokens-1:0][CounterBits-1:0]       ln_o,
  output logic [cst_pkg::MaxTokens-1:0][CounterBits-1:0]       col_o,
  output logic [cst_pkg::MaxTokens-1:0][OffsetBits-1:0]        off_o,
  output logic [cst_pkg::MaxTokens-1:0][CounterBits-1:0]       len_o
);
  import cst_pkg::*;

  localparam int KIdxBits = $clog2(KeywordChars);

  typedef struct packed {
    logic                   v;
    tok_e                   t;
    logic [CounterBits-1:0] ln;
    logic [CounterBits-1:0] col;
    logic [OffsetBits-1:0]  off;
    logic [CounterBits-1:0] len;
  } slot_t;

  mode_e                  mode_q, mode_d;
  logic [7:0]             held_q, held_d;
  logic                   cr_q, cr_d;
  logic [OffsetBits-1:0]  src_q, src_d;
  logic [CounterBits-1:0] line_q, line_d, col_q, col_d, scol_q, scol_d;
  logic [CounterBits-1:0] tlen_q, tlen_d;
  logic [OffsetBits-1:0]  soff_q, soff_d;
  logic [7:0]             kb_q [KeywordChars];
  logic [7:0]             kb_d [KeywordChars];
  logic                   accept;
  slot_t                  sl [4];
  logic [2:0]             k;

  function automatic logic [CounterBits-1:0] sat(input logic [CounterBits-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [OffsetBits-1:0] sat_off(input logic [OffsetBits-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic tok_e ident_type(input logic [7:0] b [KeywordChars],
                                      input logic [CounterBits-1:0] len);
    logic [63:0] w;
    logic [3:0]  l4;
    for (int i = 0; i < 8; i++) w[63-8*i -: 8] = b[i];
    l4 = (len > CounterBits'(8)) ? 4'hF : len[3:0];
    return kw_lookup(w, l4);
  endfunction

  function automatic slot_t mk(input tok_e t, input logic [CounterBits-1:0] ln,
                               input logic [CounterBits-1:0] col,
                               input logic [OffsetBits-1:0] off,
                               input logic [CounterBits-1:0] len);
    return '{v: 1'b1, t: t, ln: ln, col: col, off: off, len: len};
  endfunction

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  always_comb begin
    logic [7:0] c;
    logic       fin, do_idle, body;
    held_t      hk;
    c       = char_code_i;
    fin     = end_of_source_i;
    do_idle = 1'b0;
    body    = 1'b0;
    mode_d  = mode_q;
    held_d  = held_q;
    cr_d    = 1'b0;
    line_d  = line_q;
    col_d   = col_q;
    scol_d  = scol_q;
    soff_d  = soff_q;
    tlen_d  = tlen_q;
    kb_d    = kb_q;
    hk      = held_kinds(held_q);
    for (int i = 0; i < 4; i++) sl[i] = '0;

    unique case (mode_q)
      M_HOLD: begin
        if (held_q == "/" && c == "/") begin
          mode_d = M_LINE;
        end else if (held_q == "/" && c == "*") begin
          mode_d = M_BLOCK;
        end else if (hk.has_pair && c == hk.pair) begin
          col_d  = sat(sat(col_d));
          sl[0]  = mk(hk.two, line_d, sat(scol_d), soff_d, CounterBits'(2));
          mode_d = M_IDLE;
        end else begin
          col_d   = sat(col_d);
          sl[0]   = mk(hk.one, line_d, scol_d, soff_d, CounterBits'(1));
          mode_d  = M_IDLE;
          do_idle = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_letter(c) || is_digit(c) || c == "_") begin
          if (tlen_d < CounterBits'(KeywordChars)) kb_d[tlen_d[KIdxBits-1:0]] = c;
          col_d  = sat(col_d);
          tlen_d = sat(tlen_d);
        end else begin
          sl[0]   = mk(ident_type(kb_q, tlen_d), line_d, scol_d, soff_d, tlen_d);
          mode_d  = M_IDLE;
          do_idle = 1'b1;
        end
      end
      M_ZERO: begin
        if (c == "x" || is_digit(c)) begin
          col_d  = sat(col_d);
          tlen_d = sat(tlen_d);
          mode_d = (c == "x") ? M_ADDR : M_NUMBER;
        end else begin
          sl[0]   = mk(TK_NUMBER, line_d, scol_d, soff_d, tlen_d);
          mode_d  = M_IDLE;
          do_idle = 1'b1;
        end
      end
      M_NUMBER, M_ADDR: begin
        if ((mode_q == M_NUMBER) ? is_digit(c) : is_hex(c)) begin
          col_d  = sat(col_d);
          tlen_d = sat(tlen_d);
        end else begin
          sl[0]   = mk((mode_q == M_ADDR) ? TK_ADDR : TK_NUMBER, line_d, scol_d,
                       soff_d, tlen_d);
          mode_d  = M_IDLE;
          do_idle = 1'b1;
        end
      end
      M_STR: begin
        if (c == "\"") begin
          col_d  = sat(col_d);
          sl[0]  = mk(TK_STRING, line_d, scol_d, soff_d, tlen_d);
          mode_d = M_IDLE;
        end else begin
          col_d  = sat(col_d);
          tlen_d = sat(tlen_d);
          if (c == "\\") mode_d = M_STR_ESC;
        end
      end
      M_STR_ESC: begin
        col_d  = sat(col_d);
        tlen_d = sat(tlen_d);
        mode_d = M_STR;
      end
      M_LINE: begin
        if (c == "\n") begin
          line_d = sat(line_d);
          col_d  = CounterBits'(1);
          mode_d = M_IDLE;
        end
      end
      M_BLOCK_STAR: begin
        if (c == "/") begin
          mode_d = M_IDLE;
        end else begin
          col_d = sat(col_d);
          body  = 1'b1;
        end
      end
      M_BLOCK: body = 1'b1;
      default: do_idle = !(cr_q && c == "\n");
    endcase

    // block comment body byte
    if (body) begin
      if (fin) begin
        do_idle = 1'b1;
      end else if (c == "*") begin
        mode_d = M_BLOCK_STAR;
      end else if (c == "\n") begin
        line_d = sat(line_d);
        col_d  = CounterBits'(1);
        mode_d = M_BLOCK;
      end else begin
        col_d  = sat(col_d);
        mode_d = M_BLOCK;
      end
    end

    // byte between tokens
    if (do_idle) begin
      mode_d = M_IDLE;
      if (c == " " || c == "\t") begin
        col_d = sat(col_d);
      end else if (c == "\n" || c == "\r") begin
        line_d = sat(line_d);
        col_d  = CounterBits'(1);
        cr_d   = (c == "\r");
      end else if (is_letter(c) || c == "_") begin
        soff_d   = src_q;
        scol_d   = col_d;
        kb_d[0]  = c;
        col_d    = sat(col_d);
        tlen_d   = CounterBits'(1);
        mode_d   = M_IDENT;
      end else if (is_digit(c)) begin
        soff_d = src_q;
        scol_d = col_d;
        col_d  = sat(col_d);
        tlen_d = CounterBits'(1);
        mode_d = (c == "0") ? M_ZERO : M_NUMBER;
      end else if (c == "\"") begin
        scol_d = col_d;
        soff_d = sat_off(src_q);
        tlen_d = '0;
        col_d  = sat(col_d);
        mode_d = M_STR;
      end else if (is_op_start(c)) begin
        soff_d = src_q;
        scol_d = col_d;
        tlen_d = '0;
        held_d = c;
        mode_d = M_HOLD;
      end else begin
        soff_d = src_q;
        scol_d = col_d;
        tlen_d = '0;
        col_d  = sat(col_d);
        sl[1]  = mk(single_type(c), line_d, scol_d, soff_d, CounterBits'(1));
      end
    end

    src_d = sat_off(src_q);

    // final byte: close open token, report end, back to reset state
    if (fin) begin
      hk = held_kinds(held_d);
      unique case (mode_d)
        M_HOLD: begin
          col_d = sat(col_d);
          sl[2] = mk(hk.one, line_d, scol_d, soff_d, CounterBits'(1));
        end
        M_IDENT:
          sl[2] = mk(ident_type(kb_d, tlen_d), line_d, scol_d, soff_d, tlen_d);
        M_ZERO, M_NUMBER:
          sl[2] = mk(TK_NUMBER, line_d, scol_d, soff_d, tlen_d);
        M_ADDR:
          sl[2] = mk(TK_ADDR, line_d, scol_d, soff_d, tlen_d);
        M_STR, M_STR_ESC:
          sl[2] = mk(TK_STRING, line_d, (scol_d != '0) ? scol_d - 1'b1 : scol_d,
                     soff_d, tlen_d);
        default: sl[2] = '0;
      endcase
      sl[3]  = mk(TK_EOF, line_d, col_d, src_d, '0);
      mode_d = M_IDLE;
      held_d = '0;
      cr_d   = 1'b0;
      src_d  = '0;
      line_d = CounterBits'(1);
      col_d  = CounterBits'(1);
      soff_d = '0;
      scol_d = '0;
      tlen_d = '0;
    end
  end

  // pack up to three tokens in order, later ones dropped
  always_comb begin
    k     = '0;
    tt_o  = '0;
    ln_o  = '0;
    col_o = '0;
    off_o = '0;
    len_o = '0;
    for (int i = 0; i < 4; i++) begin
      if (sl[i].v && k < 3'd3) begin
        tt_o[k[1:0]]  = sl[i].t;
        ln_o[k[1:0]]  = sl[i].ln;
        col_o[k[1:0]] = sl[i].col;
        off_o[k[1:0]] = sl[i].off;
        len_o[k[1:0]] = sl[i].len;
        k = k + 3'd1;
      end
    end
  end

  assign cnt_o  = k[1:0];
  assign push_o = accept && (k != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      held_q <= '0;
      cr_q   <= 1'b0;
      src_q  <= '0;
      line_q <= CounterBits'(1);
      col_q  <= CounterBits'(1);
      soff_q <= '0;
      scol_q <= '0;
      tlen_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
      cr_q   <= cr_d;
      src_q  <= src_d;
      line_q <= line_d;
      col_q  <= col_d;
      soff_q <= soff_d;
      scol_q <= scol_d;
      tlen_q <= tlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) kb_q <= kb_d;
  end

endmodule

@@ hdl/cst_back.sv @@
module cst_back #(
  parameter int OffsetBits  = cst_pkg::OffsetBitsDef,
  parameter int CounterBits = cst_pkg::CounterBitsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  output logic                                    q_ready_o,
  input  logic                                    push_i,
  input  logic [1:0]                              cnt_i,
  input  logic [cst_pkg::MaxTokens-1:0][cst_pkg::TypeBits-1:0] tt_i,
  input  logic [cst_pkg::MaxTokens-1:0][CounterBits-1:0]       ln_i,
  input  logic [cst_pkg::MaxTokens-1:0][CounterBits-1:0]       col_i,
  input  logic [cst_pkg::MaxTokens-1:0][OffsetBits-1:0]        off_i,
  input  logic [cst_pkg::MaxTokens-1:0][CounterBits-1:0]       len_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [cst_pkg::TypeBits-1:0]            token_type_o,
  output logic [CounterBits-1:0]                  token_line_o,
  output logic [CounterBits-1:0]                  token_column_o,
  output logic [OffsetBits-1:0]                   token_offset_o,
  output logic [CounterBits-1:0]                  token_length_o,
  output logic                                    last_of_run_o
);
  import cst_pkg::*;

  typedef struct packed {
    logic [1:0]                               cnt;
    logic [MaxTokens-1:0][TypeBits-1:0]       tt;
    logic [MaxTokens-1:0][CounterBits-1:0]    ln;
    logic [MaxTokens-1:0][CounterBits-1:0]    col;
    logic [MaxTokens-1:0][OffsetBits-1:0]     off;
    logic [MaxTokens-1:0][CounterBits-1:0]    len;
  } ent_t;

  ent_t       q_mem [2];
  ent_t       head;
  logic       wr_q, rd_q;
  logic [1:0] fill_q, fill_d;
  logic [1:0] idx_q;
  logic       ov_q, load, last, pop;

  assign q_ready_o = (fill_q != 2'd2);
  assign head      = q_mem[rd_q];
  assign load      = (fill_q != 2'd0) && (!ov_q || out_ready_i);
  assign last      = (idx_q == head.cnt - 2'd1);
  assign pop       = load && last;
  assign fill_d    = fill_q + {1'b0, push_i} - {1'b0, pop};

  always_ff @(posedge clk_i) begin
    if (push_i) q_mem[wr_q] <= '{cnt_i, tt_i, ln_i, col_i, off_i, len_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= '0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (push_i) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      if (load) idx_q <= last ? 2'd0 : idx_q + 2'd1;
      if (load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      token_type_o   <= head.tt[idx_q];
      token_line_o   <= head.ln[idx_q];
      token_column_o <= head.col[idx_q];
      token_offset_o <= head.off[idx_q];
      token_length_o <= head.len[idx_q];
      last_of_run_o  <= last;
    end
  end

  assign out_valid_o = ov_q;

endmodule

@@ hdl/contract_source_tokenizer.sv @@
// contract source tokenizer
// input channel: one source byte per word (char_code_i) with end_of_source_i
// set on the final byte; accepted when in_valid_i and in_ready_o are high
// output channel: one token per word (type, line, column, offset, length);
// last_of_run_o marks the last token caused by one input byte
// a byte yields zero to three tokens; after the final byte any open token is
// closed, an eof token follows and the lexer returns to its reset state
// the first token of a byte is written into the queue at the accepting edge
// and is then loaded into the output register
// throughput: one byte per cycle while in_ready_o is high; the output side
// moves one token per cycle while out_ready_i is high; the tokens of a byte are
// absorbed by a two-entry queue between lexer and output before in_ready_o drops
// receiver stall: the output word holds, the queue fills, then in_ready_o
// falls; no token is lost or repeated
// reset: asynchronous, active low; line and column restart at one, offsets
// at zero, queue and output register empty
module contract_source_tokenizer #(
  parameter int OffsetBits   = cst_pkg::OffsetBitsDef,
  parameter int CounterBits  = cst_pkg::CounterBitsDef,
  parameter int KeywordChars = cst_pkg::KeywordCharsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   char_code_i,
  input  logic                         end_of_source_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cst_pkg::TypeBits-1:0] token_type_o,
  output logic [CounterBits-1:0]       token_line_o,
  output logic [CounterBits-1:0]       token_column_o,
  output logic [OffsetBits-1:0]        token_offset_o,
  output logic [CounterBits-1:0]       token_length_o,
  output logic                         last_of_run_o
);
  import cst_pkg::*;

  // bundle of up to three tokens from the lexer into the queue
  logic                                   q_ready, push;
  logic [1:0]                             cnt;
  logic [MaxTokens-1:0][TypeBits-1:0]     tt;
  logic [MaxTokens-1:0][CounterBits-1:0]  ln, col, len;
  logic [MaxTokens-1:0][OffsetBits-1:0]   off;

  cst_front #(
    .OffsetBits  (OffsetBits),
    .CounterBits (CounterBits),
    .KeywordChars(KeywordChars)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .char_code_i,
    .end_of_source_i,
    .q_ready_i(q_ready),
    .push_o   (push),
    .cnt_o    (cnt),
    .tt_o     (tt),
    .ln_o     (ln),
    .col_o    (col),
    .off_o    (off),
    .len_o    (len)
  );

  cst_back #(
    .OffsetBits (OffsetBits),
    .CounterBits(CounterBits)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_ready_o(q_ready),
    .push_i   (push),
    .cnt_i    (cnt),
    .tt_i     (tt),
    .ln_i     (ln),
    .col_i    (col),
    .off_i    (off),
    .len_i    (len),
    .out_valid_o,
    .out_ready_i,
    .token_type_o,
    .token_line_o,
    .token_column_o,
    .token_offset_o,
    .token_length_o,
    .last_of_run_o
  );

`ifndef ASSERT_OFF
  // eof always closes the run of its byte and carries no text
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_type_o == TK_EOF |-> last_of_run_o && token_length_o == '0)
    else $error("eof word not last or not empty");

  // line numbers start at one and never wrap to zero
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_line_o != '0)
    else $error("token line is zero");

  // a lexer bundle is only pushed while the queue has room
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> q_ready && cnt != 2'd0)
    else $error("push into full queue or empty bundle");
`endif

endmodule

@@ verif/contract_source_tokenizer_tb.sv @@
`timescale 1ns / 100ps

module contract_source_tokenizer_tb;
  import cst_pkg::*;

  localparam int unsigned CntMax    = 65535;
  localparam int unsigned OffMax    = (1 << 20) - 1;
  localparam int          IdleLimit = 5000;

  typedef struct {
    logic [5:0]  typ;
    logic [15:0] line;
    logic [15:0] col;
    logic [19:0] off;
    logic [15:0] len;
    logic        last;
  } token_t;

  // one source byte of the directed table; pinned rows carry a typed token
  typedef struct {
    byte unsigned c;
    bit           eos;
    bit           pinned;
    token_t       tok;
  } src_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i = 8'h00;
  logic        end_of_source_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  token_type_o;
  logic [15:0] token_line_o;
  logic [15:0] token_column_o;
  logic [19:0] token_offset_o;
  logic [15:0] token_length_o;
  logic        last_of_run_o;

  always #1 clk_i = ~clk_i;

  contract_source_tokenizer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .end_of_source_i(end_of_source_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_type_o   (token_type_o),
    .token_line_o   (token_line_o),
    .token_column_o (token_column_o),
    .token_offset_o (token_offset_o),
    .token_length_o (token_length_o),
    .last_of_run_o  (last_of_run_o)
  );

  // keyword spellings in token order starting at KW_CONTRACT
  string kw_words[28] = '{"contract", "function", "return", "if", "else", "while", "for",
                          "var", "const", "public", "private", "view", "pure", "payable",
                          "uint8", "uint16", "uint32", "uint64", "uint256", "int8", "int16",
                          "int32", "int64", "int256", "bool", "address", "bytes", "string"};

  // ---------------------------------------------------------------------------
  // lexer shadow state
  // ---------------------------------------------------------------------------
  mode_e          lx_mode;
  byte unsigned   lx_held;
  bit             lx_cr;
  int unsigned    lx_pos, lx_line, lx_col, lx_start_off, lx_start_col, lx_len;
  byte unsigned   lx_word[8];
  token_t         step_tokens[$];
  token_t         expected_tokens[$];
  src_row_t       pinned_q[$];

  int  error_count = 0;
  bit  calm = 1'b0;        // no gaps on the sender while set

  function automatic int unsigned sat_inc(int unsigned v);
    return (v < CntMax) ? v + 1 : v;
  endfunction

  function automatic bit alpha_c(byte unsigned c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit_c(byte unsigned c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit hex_c(byte unsigned c);
    return digit_c(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  task automatic lex_reset();
    lx_mode = M_IDLE;
    lx_held = 0;
    lx_cr = 0;
    lx_pos = 0;
    lx_line = 1;
    lx_col = 1;
    lx_start_off = 0;
    lx_start_col = 0;
    lx_len = 0;
  endtask

  task automatic emit(tok_e t, int unsigned col, int unsigned off, int unsigned len);
    token_t k;
    k.typ = t;
    k.line = lx_line[15:0];
    k.col = col[15:0];
    k.off = off[19:0];
    k.len = len[15:0];
    k.last = 1'b0;
    if (step_tokens.size() < MaxTokens) step_tokens.insert(step_tokens.size(), k);
  endtask

  // pairing byte (or none), two-char and one-char kinds of a pending operator
  task automatic op_kinds(byte unsigned h, output int pair, output tok_e two, output tok_e one);
    pair = 256;
    two = TK_UNKNOWN;
    one = TK_UNKNOWN;
    case (h)
      "=": begin pair = "="; two = TK_EQ_EQ;   one = TK_EQ;    end
      "!": begin pair = "="; two = TK_NE;      one = TK_NOT;   end
      "<": begin pair = "="; two = TK_LE;      one = TK_LT;    end
      ">": begin pair = "="; two = TK_GE;      one = TK_GT;    end
      "&": begin pair = "&"; two = TK_AND_AND;                 end
      "|": begin pair = "|"; two = TK_OR_OR;                   end
      "+": begin pair = "+"; two = TK_INC;     one = TK_PLUS;  end
      "-": begin pair = "-"; two = TK_DEC;     one = TK_MINUS; end
      "/": begin two = TK_DIV; one = TK_DIV;                   end
      default: ;
    endcase
  endtask

  function automatic tok_e punct_kind(byte unsigned c);
    case (c)
      "*": return TK_STAR;
      "%": return TK_MOD;
      ";": return TK_SEMI;
      ",": return TK_COMMA;
      ".": return TK_DOT;
      ":": return TK_COLON;
      "?": return TK_QUEST;
      "(": return TK_LPAREN;
      ")": return TK_RPAREN;
      "{": return TK_LBRACE;
      "}": return TK_RBRACE;
      "[": return TK_LBRACK;
      "]": return TK_RBRACK;
      default: return TK_UNKNOWN;
    endcase
  endfunction

  task automatic flush_held();
    int   pair;
    tok_e two, one;
    op_kinds(lx_held, pair, two, one);
    lx_col = sat_inc(lx_col);
    emit(one, lx_start_col, lx_start_off, 1);
    lx_mode = M_IDLE;
  endtask

  task automatic open_token();
    lx_start_off = lx_pos;
    lx_start_col = lx_col;
    lx_len = 0;
  endtask

  task automatic grow_token();
    lx_col = sat_inc(lx_col);
    lx_len = sat_inc(lx_len);
  endtask

  // identifier, number or address ends
  task automatic close_word();
    tok_e  t;
    string s;
    t = TK_IDENT;
    if (lx_mode == M_IDENT) begin
      s = "";
      if (lx_len <= 8)
        for (int i = 0; i < lx_len; i++) s = {s, string'(lx_word[i])};
      for (int i = 0; i < 28; i++)
        if (lx_len <= 8 && s == kw_words[i]) t = tok_e'(KW_CONTRACT + i);
      if (lx_len <= 8 && (s == "true" || s == "false")) t = TK_BOOL_LIT;
    end else if (lx_mode == M_ADDR) begin
      t = TK_ADDR;
    end else begin
      t = TK_NUMBER;
    end
    emit(t, lx_start_col, lx_start_off, lx_len);
    lx_mode = M_IDLE;
  endtask

  task automatic start_byte(byte unsigned c);
    lx_mode = M_IDLE;
    if (c == " " || c == "\t") begin
      lx_col = sat_inc(lx_col);
    end else if (c == "\n" || c == "\r") begin
      lx_line = sat_inc(lx_line);
      lx_col = 1;
      lx_cr = (c == "\r");
    end else if (alpha_c(c) || c == "_") begin
      open_token();
      lx_word[0] = c;
      grow_token();
      lx_mode = M_IDENT;
    end else if (digit_c(c)) begin
      open_token();
      grow_token();
      lx_mode = (c == "0") ? M_ZERO : M_NUMBER;
    end else if (c == "\"") begin
      lx_start_col = lx_col;
      lx_start_off = (lx_pos < OffMax) ? lx_pos + 1 : OffMax;
      lx_len = 0;
      lx_col = sat_inc(lx_col);
      lx_mode = M_STR;
    end else if (c inside {"=", "!", "<", ">", "&", "|", "+", "-", "/"}) begin
      open_token();
      lx_held = c;
      lx_mode = M_HOLD;
    end else begin
      open_token();
      lx_col = sat_inc(lx_col);
      emit(punct_kind(c), lx_start_col, lx_start_off, 1);
    end
  endtask

  task automatic comment_body(byte unsigned c, bit eos);
    if (eos) begin
      start_byte(c);       // last byte of an open block comment is lexed
    end else if (c == "*") begin
      lx_mode = M_BLOCK_STAR;
    end else if (c == "\n") begin
      lx_line = sat_inc(lx_line);
      lx_col = 1;
      lx_mode = M_BLOCK;
    end else begin
      lx_col = sat_inc(lx_col);
      lx_mode = M_BLOCK;
    end
  endtask

  // tokens caused by one source byte land in step_tokens
  task automatic lex_byte(byte unsigned c, bit eos);
    bit   was_cr;
    int   pair;
    tok_e two, one;
    was_cr = lx_cr;
    lx_cr = 0;
    step_tokens.delete();
    case (lx_mode)
      M_HOLD: begin
        if (lx_held == "/" && c == "/") lx_mode = M_LINE;
        else if (lx_held == "/" && c == "*") lx_mode = M_BLOCK;
        else begin
          op_kinds(lx_held, pair, two, one);
          if (int'(c) == pair) begin
            lx_col = sat_inc(sat_inc(lx_col));
            // two-char operators report start column plus one
            emit(two, sat_inc(lx_start_col), lx_start_off, 2);
            lx_mode = M_IDLE;
          end else begin
            flush_held();
            start_byte(c);
          end
        end
      end
      M_IDENT: begin
        if (alpha_c(c) || digit_c(c) || c == "_") begin
          if (lx_len < 8) lx_word[lx_len] = c;
          grow_token();
        end else begin
          close_word();
          start_byte(c);
        end
      end
      M_ZERO: begin
        if (c == "x") begin
          grow_token();
          lx_mode = M_ADDR;
        end else if (digit_c(c)) begin
          grow_token();
          lx_mode = M_NUMBER;
        end else begin
          close_word();
          start_byte(c);
        end
      end
      M_NUMBER, M_ADDR: begin
        if (lx_mode == M_NUMBER ? digit_c(c) : hex_c(c)) grow_token();
        else begin
          close_word();
          start_byte(c);
        end
      end
      M_STR: begin
        if (c == "\"") begin
          lx_col = sat_inc(lx_col);
          emit(TK_STRING, lx_start_col, lx_start_off, lx_len);
          lx_mode = M_IDLE;
        end else begin
          grow_token();
          if (c == "\\") lx_mode = M_STR_ESC;
        end
      end
      M_STR_ESC: begin
        grow_token();
        lx_mode = M_STR;
      end
      M_LINE: begin
        if (c == "\n") begin
          lx_line = sat_inc(lx_line);
          lx_col = 1;
          lx_mode = M_IDLE;
        end
      end
      M_BLOCK_STAR: begin
        if (c == "/") lx_mode = M_IDLE;
        else begin
          lx_col = sat_inc(lx_col);
          comment_body(c, eos);
        end
      end
      M_BLOCK: comment_body(c, eos);
      default: if (!(was_cr && c == "\n")) start_byte(c);
    endcase
    lx_pos = (lx_pos < OffMax) ? lx_pos + 1 : OffMax;
    if (eos) begin
      if (lx_mode == M_HOLD) flush_held();
      else if (lx_mode inside {M_IDENT, M_ZERO, M_NUMBER, M_ADDR}) close_word();
      else if (lx_mode inside {M_STR, M_STR_ESC})
        // unterminated string reports start column minus one
        emit(TK_STRING, (lx_start_col > 0) ? lx_start_col - 1 : 0, lx_start_off, lx_len);
      emit(TK_EOF, lx_col, lx_pos, 0);
      lex_reset();
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // scoreboard: predict on every accepted byte, check every accepted token
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    token_t   want;
    src_row_t row;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected token type %0d line %0d col %0d", token_type_o,
                     token_line_o, token_column_o);
        end else begin
          want = expected_tokens.pop_front();
          if (token_type_o !== want.typ || token_line_o !== want.line ||
              token_column_o !== want.col || token_offset_o !== want.off ||
              token_length_o !== want.len || last_of_run_o !== want.last) begin
            error_count++;
            if (error_count <= 10)
              $display({"token mismatch exp t%0d l%0d c%0d o%0d n%0d e%0d",
                        " got t%0d l%0d c%0d o%0d n%0d e%0d"},
                       want.typ, want.line, want.col, want.off, want.len, want.last,
                       token_type_o, token_line_o, token_column_o, token_offset_o,
                       token_length_o, last_of_run_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        row = pinned_q.pop_front();
        lex_byte(char_code_i, end_of_source_i);
        // directed rows with a typed token replace the predicted one
        if (row.pinned && step_tokens.size() == 1) begin
          step_tokens[0] = row.tok;
          step_tokens[0].last = 1'b1;
        end
        foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
      end
      // watchdog on handshake progress
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: bursts of ready with mostly short stalls
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(20, 1)) @(posedge clk_i);
      g = pick_gap();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  task automatic send_row(src_row_t row);
    int g;
    g = calm ? 0 : pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= row.c;
    end_of_source_i <= row.eos;
    pinned_q.insert(pinned_q.size(), row);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_byte(byte unsigned c, bit eos);
    src_row_t row;
    row.c = c;
    row.eos = eos;
    row.pinned = 0;
    send_row(row);
  endtask

  function automatic src_row_t plain(byte unsigned c, bit eos = 0);
    src_row_t row;
    row.c = c;
    row.eos = eos;
    row.pinned = 0;
    return row;
  endfunction

  function automatic src_row_t pinned(byte unsigned c, tok_e t, int line, int col, int off);
    src_row_t row;
    row.c = c;
    row.eos = 0;
    row.pinned = 1;
    row.tok = '{typ: t, line: 16'(line), col: 16'(col), off: 20'(off), len: 16'd1,
                last: 1'b1};
    return row;
  endfunction

  task automatic put_byte(ref byte unsigned q[$], input int unsigned b);
    q.insert(q.size(), 8'(b));
  endtask

  // random source fragment, mostly well formed
  task automatic add_fragment(ref byte unsigned src[$]);
    string ops[] = '{"==", "!=", "<=", ">=", "&&", "||", "++", "--", "=", "!", "<", ">",
                     "+", "-", "/", "*", "%", ";", ",", ".", ":", "?", "(", ")", "{",
                     "}", "[", "]", "&", "|"};
    string pick;
    int    n;
    case ($urandom_range(10))
      0, 1: begin
        pick = ($urandom_range(5) == 0) ? (($urandom_range(1) == 1) ? "true" : "false")
                                        : kw_words[$urandom_range(27)];
        for (int i = 0; i < pick.len(); i++) put_byte(src, pick[i]);
        if ($urandom_range(3) == 0) put_byte(src, "_");
      end
      2: begin
        n = $urandom_range(12, 1);
        put_byte(src, ($urandom_range(4) == 0) ? "_" : "a" + $urandom_range(25));
        repeat (n - 1) begin
          case ($urandom_range(3))
            0: put_byte(src, "0" + $urandom_range(9));
            1: put_byte(src, "A" + $urandom_range(25));
            2: put_byte(src, "_");
            default: put_byte(src, "a" + $urandom_range(25));
          endcase
        end
      end
      3: repeat ($urandom_range(6, 1)) put_byte(src, "0" + $urandom_range(9));
      4: begin
        put_byte(src, "0");
        if ($urandom_range(3) != 0) begin
          put_byte(src, "x");
          repeat ($urandom_range(8)) begin
            case ($urandom_range(2))
              0: put_byte(src, "0" + $urandom_range(9));
              1: put_byte(src, "a" + $urandom_range(5));
              default: put_byte(src, "A" + $urandom_range(5));
            endcase
          end
        end
      end
      5: begin
        put_byte(src, "\"");
        repeat ($urandom_range(6)) begin
          if ($urandom_range(4) == 0) begin
            put_byte(src, "\\");
            put_byte(src, ($urandom_range(1) == 1) ? "\"" : "n");
          end else begin
            put_byte(src, ($urandom_range(5) == 0) ? "\n" : " " + $urandom_range(94));
            if (src[$] == "\"") src[$] = "q";
          end
        end
        if ($urandom_range(5) != 0) put_byte(src, "\"");
      end
      6: begin
        pick = ops[$urandom_range(ops.size() - 1)];
        for (int i = 0; i < pick.len(); i++) put_byte(src, pick[i]);
      end
      7: begin
        case ($urandom_range(4))
          0: put_byte(src, "\t");
          1: put_byte(src, "\n");
          2: put_byte(src, "\r");
          3: begin put_byte(src, "\r"); put_byte(src, "\n"); end
          default: put_byte(src, " ");
        endcase
      end
      8: begin
        put_byte(src, "/");
        put_byte(src, "/");
        repeat ($urandom_range(5)) put_byte(src, "a" + $urandom_range(25));
        if ($urandom_range(3) != 0) put_byte(src, "\n");
      end
      9: begin
        put_byte(src, "/");
        put_byte(src, "*");
        repeat ($urandom_range(6)) begin
          case ($urandom_range(3))
            0: put_byte(src, "*");
            1: put_byte(src, "\n");
            default: put_byte(src, "a" + $urandom_range(25));
          endcase
        end
        if ($urandom_range(4) != 0) begin put_byte(src, "*"); put_byte(src, "/"); end
      end
      default: put_byte(src, $urandom_range(255));
    endcase
    if ($urandom_range(2) == 0) put_byte(src, " ");
  endtask

  initial begin
    src_row_t     dir_tab[$];
    byte unsigned src[$];
    int           sent;
    bit           paused;
    lex_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk: extremes, operator pairing, comments, cr-lf, eof cases
    dir_tab = '{pinned("(", TK_LPAREN, 1, 1, 0), plain("x"), plain("="), plain("="),
                pinned(8'h00, TK_UNKNOWN, 1, 5, 4), pinned(8'hFF, TK_UNKNOWN, 1, 6, 5),
                plain("0"), plain("x"), plain("f"), plain("\r"), plain("\n"),
                plain("\""), plain("\\"), plain("\""), plain("\""),
                plain("/"), plain("*"), plain("*"), plain("/"), plain("&"), plain(" "),
                plain("/"), plain("/"), plain("q"), plain("\n"), plain("!", 1),
                plain("\""), plain("a", 1), plain("/"), plain("*"), plain("z", 1)};
    foreach (dir_tab[i]) send_row(dir_tab[i]);

    // random sources; one pause until the output side has drained
    sent = 0;
    paused = 1'b0;
    while (sent < 340) begin
      src.delete();
      calm = ($urandom_range(3) == 0);
      repeat ($urandom_range(15, 4)) add_fragment(src);
      foreach (src[i]) send_byte(src[i], i == src.size() - 1);
      sent += src.size();
      if (!paused && sent > 150) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (expected_tokens.size() != 0) @(posedge clk_i);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
